@@ rtl/dcc_pkg.sv @@
`default_nettype none

package dcc_pkg;

    // Field widths of the channels.
    localparam int unsigned DAY_COUNT_W = 32;
    localparam int unsigned MILLIS_W    = 32;
    localparam int unsigned YEAR_W      = 7;
    localparam int unsigned MONTH_W     = 4;
    localparam int unsigned MDAY_W      = 5;
    localparam int unsigned WEEKDAY_W   = 3;
    localparam int unsigned HOUR_W      = 5;
    localparam int unsigned MINUTE_W    = 6;
    localparam int unsigned SECOND_W    = 6;

    // Only the low bits of a time stamp matter once its range is checked.
    localparam int unsigned DAY_LOW_W = 16;
    localparam int unsigned MS_LOW_W  = 27;

    // Cycles spent in each of the date and time paths.
    localparam int unsigned PATH_LATENCY = 6;

    localparam logic [MILLIS_W-1:0]    MS_PER_DAY = 32'd86400000;
    localparam logic [DAY_COUNT_W-1:0] FIRST_DAY  = 32'd5844;
    localparam logic [DAY_COUNT_W-1:0] LAST_DAY   = 32'd42368;

    localparam logic [DAY_LOW_W-1:0] DAYS_PER_CYCLE = 16'd1461;
    localparam logic [DAY_LOW_W-1:0] DAYS_PER_WEEK  = 16'd7;
    localparam logic [10:0] END_YEAR0 = 11'd366;
    localparam logic [10:0] END_YEAR1 = 11'd731;
    localparam logic [10:0] END_YEAR2 = 11'd1096;

    // Reciprocals for exact division over the value ranges in use.
    localparam logic [15:0] RECIP_CYCLE = 16'd45934;      // /1461, shift 26
    localparam logic [16:0] RECIP_WEEK  = 17'd74899;      // /7, shift 19
    localparam logic [26:0] RECIP_MILLI = 27'd68719477;   // /1000, shift 36
    localparam logic [17:0] RECIP_MIN   = 18'd139811;     // /60 below 2^17, shift 23
    localparam logic [12:0] RECIP_HOUR  = 13'd4370;       // /60 below 2^11, shift 18

    typedef struct packed {
        logic [YEAR_W-1:0]    year_offset;
        logic [MONTH_W-1:0]   month_number;
        logic [MDAY_W-1:0]    day_of_month;
        logic [WEEKDAY_W-1:0] weekday_number;
    } date_t;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour_value;
        logic [MINUTE_W-1:0] minute_value;
        logic [SECOND_W-1:0] second_value;
    } tod_t;

    // Day of year on which month idx (0 = January) begins.
    function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
        logic [8:0] base;
        begin
            unique case (idx)
                4'd0:    base = 9'd0;
                4'd1:    base = 9'd31;
                4'd2:    base = 9'd59;
                4'd3:    base = 9'd90;
                4'd4:    base = 9'd120;
                4'd5:    base = 9'd151;
                4'd6:    base = 9'd181;
                4'd7:    base = 9'd212;
                4'd8:    base = 9'd243;
                4'd9:    base = 9'd273;
                4'd10:   base = 9'd304;
                4'd11:   base = 9'd334;
                default: base = 9'd0;
            endcase
            if (leap && (idx >= 4'd2))
            begin
                base = base + 9'd1;
            end
            return base;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/dcc_if.sv @@
`default_nettype none

interface dcc_stamp_if;
    logic                             valid;
    logic                             ready;
    logic [dcc_pkg::DAY_COUNT_W-1:0]  day_count;
    logic [dcc_pkg::MILLIS_W-1:0]     millis_of_day;

    modport source (output valid, output day_count, output millis_of_day, input ready);
    modport sink   (input valid, input day_count, input millis_of_day, output ready);
endinterface

interface dcc_result_if;
    logic                           valid;
    logic                           ready;
    logic                           range_error;
    logic [dcc_pkg::YEAR_W-1:0]     year_offset;
    logic [dcc_pkg::MONTH_W-1:0]    month_number;
    logic [dcc_pkg::MDAY_W-1:0]     day_of_month;
    logic [dcc_pkg::WEEKDAY_W-1:0]  weekday_number;
    logic [dcc_pkg::HOUR_W-1:0]     hour_value;
    logic [dcc_pkg::MINUTE_W-1:0]   minute_value;
    logic [dcc_pkg::SECOND_W-1:0]   second_value;

    modport source (output valid, output range_error, output year_offset,
                    output month_number, output day_of_month, output weekday_number,
                    output hour_value, output minute_value, output second_value,
                    input ready);
    modport sink   (input valid, input range_error, input year_offset,
                    input month_number, input day_of_month, input weekday_number,
                    input hour_value, input minute_value, input second_value,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/dcc_date_path.sv @@
`default_nettype none

module dcc_date_path (
    input  logic                            clk,
    input  logic                            en,
    input  logic [dcc_pkg::DAY_LOW_W-1:0]   day_low,
    output dcc_pkg::date_t                  date
);
    import dcc_pkg::*;

    logic [DAY_LOW_W-1:0] rel1_reg, rel1_next, day1_reg;
    logic [DAY_LOW_W-1:0] rel2_reg, day2_reg;
    logic [4:0]           cyc2_reg, cyc2_next;
    logic [12:0]          wk2_reg, wk2_next;
    logic [4:0]           cyc3_reg;
    logic [10:0]          rest3_reg, rest3_next;
    logic [2:0]           wd3_reg, wd3_next;
    logic [4:0]           cyc4_reg;
    logic [1:0]           yic4_reg, yic4_next;
    logic [8:0]           yday4_reg, yday4_next;
    logic                 leap4_reg, leap4_next;
    logic [2:0]           wd4_reg;
    logic [YEAR_W-1:0]    year5_reg;
    logic [3:0]           mon5_reg, mon5_next;
    logic [8:0]           yday5_reg;
    logic                 leap5_reg;
    logic [2:0]           wd5_reg;
    date_t                date_reg, date_next;

    logic [31:0]          prod_cyc;
    logic [32:0]          prod_wk;
    logic [DAY_LOW_W-1:0] diff_cyc, diff_wk;
    logic [8:0]           mday_full;

    assign rel1_next = day_low - FIRST_DAY[DAY_LOW_W-1:0];

    always_comb
    begin
        prod_cyc  = 32'(rel1_reg) * 32'(RECIP_CYCLE);
        prod_wk   = 33'(day1_reg) * 33'(RECIP_WEEK);
        cyc2_next = prod_cyc[30:26];
        wk2_next  = prod_wk[31:19];
    end

    always_comb
    begin
        diff_cyc   = rel2_reg - (DAY_LOW_W'(cyc2_reg) * DAYS_PER_CYCLE);
        diff_wk    = day2_reg - (DAY_LOW_W'(wk2_reg) * DAYS_PER_WEEK);
        rest3_next = diff_cyc[10:0];
        // Day zero of the count was a Sunday, which is weekday seven.
        wd3_next   = (diff_wk[2:0] == 3'd0) ? 3'd7 : diff_wk[2:0];
    end

    // The first year of every four-year cycle is the leap year.
    always_comb
    begin
        priority if (rest3_reg < END_YEAR0)
        begin
            yic4_next  = 2'd0;
            yday4_next = rest3_reg[8:0];
            leap4_next = 1'b1;
        end
        else if (rest3_reg < END_YEAR1)
        begin
            yic4_next  = 2'd1;
            yday4_next = 9'(rest3_reg - END_YEAR0);
            leap4_next = 1'b0;
        end
        else if (rest3_reg < END_YEAR2)
        begin
            yic4_next  = 2'd2;
            yday4_next = 9'(rest3_reg - END_YEAR1);
            leap4_next = 1'b0;
        end
        else
        begin
            yic4_next  = 2'd3;
            yday4_next = 9'(rest3_reg - END_YEAR2);
            leap4_next = 1'b0;
        end
    end

    always_comb
    begin
        mon5_next = 4'd0;
        for (int i = 1; i < 12; i++)
        begin
            if (yday4_reg >= month_start(4'(i), leap4_reg))
            begin
                mon5_next = 4'(i);
            end
        end
    end

    always_comb
    begin
        mday_full                = yday5_reg - month_start(mon5_reg, leap5_reg) + 9'd1;
        date_next.year_offset    = year5_reg;
        date_next.month_number   = mon5_reg + 4'd1;
        date_next.day_of_month   = mday_full[MDAY_W-1:0];
        date_next.weekday_number = wd5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rel1_reg  <= rel1_next;
            day1_reg  <= day_low;
            rel2_reg  <= rel1_reg;
            day2_reg  <= day1_reg;
            cyc2_reg  <= cyc2_next;
            wk2_reg   <= wk2_next;
            cyc3_reg  <= cyc2_reg;
            rest3_reg <= rest3_next;
            wd3_reg   <= wd3_next;
            cyc4_reg  <= cyc3_reg;
            yic4_reg  <= yic4_next;
            yday4_reg <= yday4_next;
            leap4_reg <= leap4_next;
            wd4_reg   <= wd3_reg;
            year5_reg <= {cyc4_reg, yic4_reg};
            mon5_reg  <= mon5_next;
            yday5_reg <= yday4_reg;
            leap5_reg <= leap4_reg;
            wd5_reg   <= wd4_reg;
            date_reg  <= date_next;
        end
    end

    assign date = date_reg;

endmodule

`default_nettype wire

@@ rtl/dcc_time_path.sv @@
`default_nettype none

module dcc_time_path (
    input  logic                          clk,
    input  logic                          en,
    input  logic [dcc_pkg::MS_LOW_W-1:0]  ms_low,
    output dcc_pkg::tod_t                 tod
);
    import dcc_pkg::*;

    logic [MS_LOW_W-1:0] ms1_reg;
    logic [16:0]         secs2_reg, secs2_next;
    logic [16:0]         secs3_reg;
    logic [10:0]         mt3_reg, mt3_next;
    logic [10:0]         mt4_reg;
    logic [HOUR_W-1:0]   hr4_reg, hr4_next;
    logic [SECOND_W-1:0] sec4_reg, sec4_next;
    logic [HOUR_W-1:0]   hr5_reg;
    logic [MINUTE_W-1:0] min5_reg, min5_next;
    logic [SECOND_W-1:0] sec5_reg;
    tod_t                tod_reg, tod_next;

    logic [53:0] prod_sec;
    logic [34:0] prod_mt;
    logic [23:0] prod_hr;
    logic [16:0] diff_sec;
    logic [10:0] diff_min;

    always_comb
    begin
        prod_sec   = 54'(ms1_reg) * 54'(RECIP_MILLI);
        secs2_next = prod_sec[52:36];
    end

    always_comb
    begin
        prod_mt  = 35'(secs2_reg) * 35'(RECIP_MIN);
        mt3_next = prod_mt[33:23];
    end

    always_comb
    begin
        diff_sec  = secs3_reg - (17'(mt3_reg) * 17'd60);
        sec4_next = diff_sec[SECOND_W-1:0];
        prod_hr   = 24'(mt3_reg) * 24'(RECIP_HOUR);
        hr4_next  = prod_hr[22:18];
    end

    always_comb
    begin
        diff_min  = mt4_reg - (11'(hr4_reg) * 11'd60);
        min5_next = diff_min[MINUTE_W-1:0];
    end

    always_comb
    begin
        tod_next.hour_value   = hr5_reg;
        tod_next.minute_value = min5_reg;
        tod_next.second_value = sec5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ms1_reg   <= ms_low;
            secs2_reg <= secs2_next;
            secs3_reg <= secs2_reg;
            mt3_reg   <= mt3_next;
            mt4_reg   <= mt3_reg;
            hr4_reg   <= hr4_next;
            sec4_reg  <= sec4_next;
            hr5_reg   <= hr4_reg;
            min5_reg  <= min5_next;
            sec5_reg  <= sec4_reg;
            tod_reg   <= tod_next;
        end
    end

    assign tod = tod_reg;

endmodule

`default_nettype wire

@@ rtl/day_count_to_calendar_core.sv @@
// An accepted stamp beat runs through the path stages, then the output registers, to its result beat.
// Throughput: one beat per cycle unless the result side stalls; the date
// path, six stages of constant reciprocal multiplies, compares and a month
// table, sets the depth. A stall on the result side holds every stage in place.
// Reset (rst_n low, asynchronous) clears all valid bits; data is not reset.
`default_nettype none

module day_count_to_calendar_core (
    input  logic          clk,
    input  logic          rst_n,
    dcc_stamp_if.sink     stamp,
    dcc_result_if.source  result
);
    import dcc_pkg::*;

    logic                en;
    logic                err_next;
    logic [PATH_LATENCY-1:0] vld_reg;
    logic [PATH_LATENCY-1:0] err_reg;
    logic                out_valid_reg;
    logic                out_err_reg;
    date_t               date;
    date_t               out_date_reg;
    tod_t                tod;
    tod_t                out_tod_reg;

    assign en          = !out_valid_reg || result.ready;
    assign stamp.ready = en;

    assign err_next = (stamp.millis_of_day >= MS_PER_DAY) ||
                      (stamp.day_count < FIRST_DAY) ||
                      (stamp.day_count > LAST_DAY);

    dcc_date_path u_date (
        .clk     (clk),
        .en      (en),
        .day_low (stamp.day_count[DAY_LOW_W-1:0]),
        .date    (date)
    );

    dcc_time_path u_time (
        .clk    (clk),
        .en     (en),
        .ms_low (stamp.millis_of_day[MS_LOW_W-1:0]),
        .tod    (tod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[PATH_LATENCY-2:0], stamp.valid};
            out_valid_reg <= vld_reg[PATH_LATENCY-1];
        end
    end

    // A failed range check zeroes every other field of the beat.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err_reg     <= {err_reg[PATH_LATENCY-2:0], err_next};
            out_err_reg <= err_reg[PATH_LATENCY-1];
            out_date_reg <= err_reg[PATH_LATENCY-1] ? '0 : date;
            out_tod_reg  <= err_reg[PATH_LATENCY-1] ? '0 : tod;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.range_error    = out_err_reg;
    assign result.year_offset    = out_date_reg.year_offset;
    assign result.month_number   = out_date_reg.month_number;
    assign result.day_of_month   = out_date_reg.day_of_month;
    assign result.weekday_number = out_date_reg.weekday_number;
    assign result.hour_value     = out_tod_reg.hour_value;
    assign result.minute_value   = out_tod_reg.minute_value;
    assign result.second_value   = out_tod_reg.second_value;

endmodule

`default_nettype wire
